>>> design/lrua_pkg.sv
`default_nettype none
package lrua_pkg;

   // Sizing
   localparam int MAX_WAYS = 8;
   localparam int NUM_SETS = 64;
   localparam int AGE_BITS = 8;

   localparam int SET_BITS     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int WAY_IDX_BITS = $clog2(MAX_WAYS);
   localparam int WAY_CNT_BITS = $clog2(MAX_WAYS + 1);
   localparam int ROW_BITS     = MAX_WAYS * AGE_BITS;
   localparam int AGE_TOP_INT  = (1 << AGE_BITS) - 1;
   localparam logic [AGE_BITS-1:0] AGE_TOP = '1;

   // Field widths
   localparam int CMD_BITS     = 1;
   localparam int SET_IN_BITS  = 6;
   localparam int WAY_IN_BITS  = 3;
   localparam int MASK_BITS    = 8;
   localparam int VICTIM_BITS  = 3;
   localparam int CFG_BITS     = 4;
   localparam int SET_IN_RANGE = 1 << SET_IN_BITS;

   // Stream packing
   localparam int REQ_SET_LSB    = 0;
   localparam int REQ_WAY_LSB    = REQ_SET_LSB + SET_IN_BITS;
   localparam int REQ_MASK_LSB   = REQ_WAY_LSB + WAY_IN_BITS;
   localparam int REQ_DATA_BITS  = 24;
   localparam int RSP_DATA_BITS  = 8;

   // Commands
   localparam logic [CMD_BITS-1:0] CMD_TOUCH = 1'b0;
   localparam logic [CMD_BITS-1:0] CMD_QUERY = 1'b1;

   // Register file
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic REG_WAYS_IN_USE = 1'b0;
   localparam logic [CFG_BITS-1:0] WAYS_IN_USE_RESET = 4'd8;

   typedef struct packed {
      logic [SET_BITS-1:0]    set_sel;
      logic                   touch;
      logic [WAY_IN_BITS-1:0] way;
      logic [MASK_BITS-1:0]   mask;
   } item_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_ISSUE,
      ST_UPDATE
   } back_state_type;

   typedef logic [SET_BITS-1:0] set_map_type [SET_IN_RANGE];

   function automatic set_map_type build_set_map();
      set_map_type m;
      for (int i = 0; i < SET_IN_RANGE; i++) begin
         m[i] = SET_BITS'(i % NUM_SETS);
      end
      return m;
   endfunction

   localparam set_map_type SET_MAP = build_set_map();

   function automatic logic [ROW_BITS-1:0] build_reset_row();
      logic [ROW_BITS-1:0] r;
      r = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         r[w*AGE_BITS +: AGE_BITS] = (w > AGE_TOP_INT) ? AGE_TOP : AGE_BITS'(w);
      end
      return r;
   endfunction

   localparam logic [ROW_BITS-1:0] RESET_ROW = build_reset_row();

endpackage
`default_nettype wire

>>> design/lrua_ram.sv
`default_nettype none
module lrua_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> design/lrua_front.sv
`default_nettype none
module lrua_front (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // [5:0] set_index, [8:6] way, [16:9] valid_mask, zero fill above
   input  wire logic [lrua_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   // [0] command
   input  wire logic [lrua_pkg::CMD_BITS-1:0]         req_tuser,
   input  wire logic [lrua_pkg::WAY_CNT_BITS-1:0]     ways_active,
   input  wire logic                                  accept_en,
   output logic                                       q_valid,
   input  wire logic                                  q_ready,
   output lrua_pkg::item_type                         q_item
);
   import lrua_pkg::*;

   localparam int QDEPTH = 2;

   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   item_type   slot_ff [QDEPTH];
   item_type   item_new;
   logic       push, pop;
   logic [SET_IN_BITS-1:0] set_raw;

   // Classify: fold the set index and decide whether the touch takes effect
   always_comb begin
      set_raw          = req_tdata[REQ_SET_LSB +: SET_IN_BITS];
      item_new.set_sel = SET_MAP[set_raw];
      item_new.way     = req_tdata[REQ_WAY_LSB +: WAY_IN_BITS];
      item_new.mask    = req_tdata[REQ_MASK_LSB +: MASK_BITS];
      item_new.touch   = (req_tuser == CMD_TOUCH) &&
                         (WAY_CNT_BITS'(item_new.way) < ways_active);
   end

   assign req_tready = accept_en && (count_ff != 2'(QDEPTH));
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != 2'd0);
   assign pop        = q_valid && q_ready;
   assign q_item     = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in  = count_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item_new;
      end
   end

endmodule
`default_nettype wire

>>> design/lrua_back.sv
`default_nettype none
module lrua_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [lrua_pkg::WAY_CNT_BITS-1:0] ways_active,
   input  wire logic                              q_valid,
   output logic                                   q_ready,
   input  wire lrua_pkg::item_type                q_item,
   output logic                                   ready_for_items,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [lrua_pkg::VICTIM_BITS-1:0]       rsp_victim
);
   import lrua_pkg::*;

   back_state_type state_ff, state_in;

   logic [SET_BITS-1:0] clr_ff, clr_in;
   item_type            cur_ff;
   logic                s3_valid_ff, s3_valid_in;
   logic [ROW_BITS-1:0] s3_row_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VICTIM_BITS-1:0] victim_ff;

   logic                ram_wr_en;
   logic [SET_BITS-1:0] ram_wr_addr;
   logic [ROW_BITS-1:0] ram_wr_data;
   logic                ram_rd_en;
   logic [ROW_BITS-1:0] ram_rd_data;
   logic                load_cur;
   logic                load_s3;
   logic                s3_advance;
   logic                s3_free;
   logic [ROW_BITS-1:0] row_upd;
   logic [MAX_WAYS+MASK_BITS-1:0] mask_ext;
   logic [AGE_BITS-1:0] age_w;
   logic [AGE_BITS-1:0] best_age;
   logic [WAY_IDX_BITS-1:0] best_idx;

   lrua_ram #(
      .WIDTH (ROW_BITS),
      .DEPTH (NUM_SETS)
   ) u_age_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (q_item.set_sel),
      .rd_data (ram_rd_data)
   );

   assign s3_advance = s3_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign s3_free    = !s3_valid_ff || s3_advance;

   // Age update of the row read for the current item
   always_comb begin
      mask_ext = (MAX_WAYS + MASK_BITS)'(cur_ff.mask);
      row_upd  = ram_rd_data;
      age_w    = '0;
      if (cur_ff.touch) begin
         for (int w = 0; w < MAX_WAYS; w++) begin
            age_w = ram_rd_data[w*AGE_BITS +: AGE_BITS];
            if (w == int'(cur_ff.way)) begin
               row_upd[w*AGE_BITS +: AGE_BITS] = '0;
            end else if ((w < int'(ways_active)) && mask_ext[w] && (age_w != AGE_TOP)) begin
               row_upd[w*AGE_BITS +: AGE_BITS] = age_w + AGE_BITS'(1);
            end
         end
      end
   end

   // Oldest way in use, lowest index on a tie
   always_comb begin
      best_idx = '0;
      best_age = s3_row_ff[AGE_BITS-1:0];
      for (int w = 1; w < MAX_WAYS; w++) begin
         if ((w < int'(ways_active)) &&
             (s3_row_ff[w*AGE_BITS +: AGE_BITS] > best_age)) begin
            best_idx = WAY_IDX_BITS'(w);
            best_age = s3_row_ff[w*AGE_BITS +: AGE_BITS];
         end
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == SET_BITS'(NUM_SETS - 1)) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (q_valid) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (s3_free) begin
               state_in = ST_ISSUE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // State outputs
   always_comb begin
      ram_wr_en       = 1'b0;
      ram_wr_addr     = cur_ff.set_sel;
      ram_wr_data     = row_upd;
      ram_rd_en       = 1'b0;
      q_ready         = 1'b0;
      load_cur        = 1'b0;
      load_s3         = 1'b0;
      ready_for_items = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en       = 1'b1;
            ram_wr_addr     = clr_ff;
            ram_wr_data     = RESET_ROW;
            ready_for_items = 1'b0;
         end
         ST_ISSUE: begin
            ram_rd_en = q_valid;
            q_ready   = 1'b1;
            load_cur  = q_valid;
         end
         ST_UPDATE: begin
            ram_wr_en = s3_free;
            load_s3   = s3_free;
         end
         default: begin
            ready_for_items = 1'b0;
         end
      endcase
   end

   always_comb begin
      clr_in = clr_ff;
      if (state_ff == ST_CLEAR) begin
         clr_in = clr_ff + SET_BITS'(1);
      end
      s3_valid_in = s3_valid_ff;
      if (load_s3) begin
         s3_valid_in = 1'b1;
      end else if (s3_advance) begin
         s3_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s3_advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_cur) begin
         cur_ff <= q_item;
      end
      if (load_s3) begin
         s3_row_ff <= row_upd;
      end
      if (s3_advance) begin
         victim_ff <= VICTIM_BITS'(best_idx);
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_victim = victim_ff;

endmodule
`default_nettype wire

>>> design/lru_age_replacement.sv
// Path: front queue slot, age RAM read register, updated-row register, then
// the response register drives rsp_tvalid. Items go one at a time: the set's
// age row is read, then written back, in the single-read, single-write age RAM.
// Reset: a clearing pass over all NUM_SETS sets (64) loads every way's age with
// its way number while req_tready stays low; ways_in_use resets to 8.
`default_nettype none
module lru_age_replacement (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // [5:0] set_index, [8:6] way, [16:9] valid_mask, zero fill above
   input  wire logic [lrua_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // [0] command
   input  wire logic [lrua_pkg::CMD_BITS-1:0]        req_tuser,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // [2:0] victim_way, zero fill above
   output logic      [lrua_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [lrua_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  wire logic [lrua_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic      [lrua_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                      csr_pready
);
   import lrua_pkg::*;

   logic [CFG_BITS-1:0]     ways_in_use_ff, ways_in_use_in;
   logic [WAY_CNT_BITS-1:0] ways_active;
   logic                    csr_write;
   logic                    reg_sel;
   logic                    accept_en;
   logic                    q_valid;
   logic                    q_ready;
   item_type                q_item;
   logic [VICTIM_BITS-1:0]  rsp_victim;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      ways_in_use_in = ways_in_use_ff;
      if (csr_write && (reg_sel == REG_WAYS_IN_USE)) begin
         ways_in_use_in = csr_pwdata[CFG_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ways_in_use_ff <= WAYS_IN_USE_RESET;
      end else begin
         ways_in_use_ff <= ways_in_use_in;
      end
   end

   assign csr_prdata = (reg_sel == REG_WAYS_IN_USE) ? CSR_DATA_BITS'(ways_in_use_ff) : '0;

   // Clamp the way count to one through MAX_WAYS
   always_comb begin
      priority if (ways_in_use_ff == '0) begin
         ways_active = WAY_CNT_BITS'(1);
      end else if (ways_in_use_ff > MAX_WAYS) begin
         ways_active = WAY_CNT_BITS'(MAX_WAYS);
      end else begin
         ways_active = WAY_CNT_BITS'(ways_in_use_ff);
      end
   end

   lrua_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .ways_active (ways_active),
      .accept_en   (accept_en),
      .q_valid     (q_valid),
      .q_ready     (q_ready),
      .q_item      (q_item)
   );

   lrua_back u_back (
      .clock           (clock),
      .reset           (reset),
      .ways_active     (ways_active),
      .q_valid         (q_valid),
      .q_ready         (q_ready),
      .q_item          (q_item),
      .ready_for_items (accept_en),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_victim      (rsp_victim)
   );

   assign rsp_tdata = {(RSP_DATA_BITS - VICTIM_BITS)'(0), rsp_victim};

endmodule
`default_nettype wire
